/* design/chte_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chte_pkg
// Shared constants, codes and controller/datapath interface types for the
// chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

	localparam int MAX_BUCKETS_DEF = 256;
	localparam int POOL_NODES_DEF  = 512;

	localparam int KEY_W    = 31;
	localparam int REC_W    = 31;
	localparam int COLL_W   = 10;
	localparam int BC_W     = 9;
	localparam int BITCNT_W = 5;

	localparam logic [BC_W-1:0]     BC_RESET = 9'd256;
	localparam logic [COLL_W-1:0]   COLL_MAX = 10'd1023;
	localparam logic [BITCNT_W-1:0] DIV_LAST = 5'd30;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic       load;
		logic       div_step;
		logic       head_rd;
		logic       insert_wr;
		logic       node_rd_head;
		logic       node_rd_link;
		logic       found_ld;
		logic       coll_inc;
		logic       sweep_start;
		logic       sweep_wr;
		logic       res_ld;
		logic [1:0] res_status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_last;
		logic hd_valid;
		logic key_match;
		logic link_valid;
		logic pool_full;
		logic sweep_last;
		logic out_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

/* design/chte_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chte_ctrl
// Sequencer for insert, lookup and clear: divider run, bucket head read,
// chain walk, bucket sweep and result hand-off.
// ----------------------------------------------------------------------------
module chte_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire chte_pkg::dp_stat_t stat,
	output chte_pkg::ctrl_cmd_t     ctl
);

	localparam logic [2:0] S_SWEEP    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_DIV      = 3'd2;
	localparam logic [2:0] S_HEAD_RD  = 3'd3;
	localparam logic [2:0] S_HEAD_CHK = 3'd4;
	localparam logic [2:0] S_NODE_CHK = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] op_q, op_d;
	logic [1:0] sta_q, sta_d;
	logic       sres_q, sres_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			op_q    <= chte_pkg::CMD_INSERT;
			sta_q   <= chte_pkg::ST_OK;
			sres_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			sta_q   <= sta_d;
			sres_q  <= sres_d;
		end
	end

	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		op_d     = op_q;
		sta_d    = sta_q;
		sres_d   = sres_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					op_d     = cmd;
					case (cmd)
						chte_pkg::CMD_INSERT: begin
							if (stat.pool_full) begin
								sta_d   = chte_pkg::ST_FULL;
								state_d = S_DONE;
							end else begin
								state_d = S_DIV;
							end
						end
						chte_pkg::CMD_LOOKUP: begin
							state_d = S_DIV;
						end
						chte_pkg::CMD_CLEAR: begin
							ctl.sweep_start = 1'b1;
							sres_d          = 1'b1;
							state_d         = S_SWEEP;
						end
						default: begin
							sta_d   = chte_pkg::ST_OK;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_HEAD_RD;
				end
			end
			S_HEAD_RD: begin
				ctl.head_rd = 1'b1;
				state_d     = S_HEAD_CHK;
			end
			S_HEAD_CHK: begin
				if (op_q == chte_pkg::CMD_INSERT) begin
					ctl.insert_wr = 1'b1;
					sta_d         = chte_pkg::ST_OK;
					state_d       = S_DONE;
				end else if (stat.hd_valid) begin
					ctl.node_rd_head = 1'b1;
					state_d          = S_NODE_CHK;
				end else begin
					sta_d   = chte_pkg::ST_MISS;
					state_d = S_DONE;
				end
			end
			S_NODE_CHK: begin
				if (stat.key_match) begin
					ctl.found_ld = 1'b1;
					sta_d        = chte_pkg::ST_OK;
					state_d      = S_DONE;
				end else begin
					ctl.coll_inc = 1'b1;
					if (stat.link_valid) begin
						ctl.node_rd_link = 1'b1;
					end else begin
						sta_d   = chte_pkg::ST_MISS;
						state_d = S_DONE;
					end
				end
			end
			S_DONE: begin
				ctl.res_status = sta_q;
				if (!stat.out_busy) begin
					ctl.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SWEEP: begin
				ctl.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					sres_d = 1'b0;
					if (sres_q) begin
						sta_d   = chte_pkg::ST_OK;
						state_d = S_DONE;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* design/chte_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chte_dp
// Datapath: bucket count register, bit-serial modulo unit, bucket head and
// node pool memories, free pointer, collision counter and result register.
// ----------------------------------------------------------------------------
module chte_dp #(
	parameter int MAX_BUCKETS = chte_pkg::MAX_BUCKETS_DEF,
	parameter int POOL_NODES  = chte_pkg::POOL_NODES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [chte_pkg::BC_W-1:0]     cfg_wdata,
	input  wire logic [chte_pkg::KEY_W-1:0]    key,
	input  wire logic [chte_pkg::REC_W-1:0]    record,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [1:0]                         status,
	output logic [chte_pkg::REC_W-1:0]         found_record,
	output logic [chte_pkg::COLL_W-1:0]        collisions,
	input  wire chte_pkg::ctrl_cmd_t           ctl,
	output chte_pkg::dp_stat_t                 stat
);

	localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int EW = $clog2(MAX_BUCKETS + 1);
	localparam int CW = (EW > chte_pkg::BC_W) ? EW : chte_pkg::BC_W;
	localparam int NW = $clog2(POOL_NODES);
	localparam int FW = NW + 1;
	localparam int KW = chte_pkg::KEY_W;
	localparam int RW = chte_pkg::REC_W;
	localparam int HW = NW + 1;
	localparam int ENW = KW + RW + 1 + NW;

	logic [chte_pkg::BC_W-1:0]     bc_q;
	logic [KW-1:0]                 key_q, keysh_q;
	logic [RW-1:0]                 rec_q;
	logic [EW-1:0]                 div_q, rem_q;
	logic [chte_pkg::BITCNT_W-1:0] cnt_q;
	logic [FW-1:0]                 free_q;
	logic [BW-1:0]                 swcnt_q;
	logic [RW-1:0]                 found_q;
	logic [chte_pkg::COLL_W-1:0]   coll_q;
	logic                          out_valid_q;
	logic [1:0]                    status_q;
	logic [RW-1:0]                 found_out_q;
	logic [chte_pkg::COLL_W-1:0]   coll_out_q;

	logic [HW-1:0]  head_mem [MAX_BUCKETS];
	logic [HW-1:0]  head_rd_q;
	logic [ENW-1:0] node_mem [POOL_NODES];
	logic [ENW-1:0] node_rd_q;

	logic [CW-1:0] bc_ext, eff_c;
	logic [EW:0]   trial, diff;
	logic          hd_valid, nd_link_valid;
	logic [NW-1:0] hd_idx, nd_link, node_raddr;
	logic [KW-1:0] nd_key;
	logic [RW-1:0] nd_rec;
	logic [BW-1:0] haddr;
	logic [HW-1:0] hwdata;
	logic          hwe;

	assign bc_ext = CW'(bc_q);
	always_comb begin
		if (bc_ext == '0) begin
			eff_c = CW'(1);
		end else if (bc_ext > CW'(MAX_BUCKETS)) begin
			eff_c = CW'(MAX_BUCKETS);
		end else begin
			eff_c = bc_ext;
		end
	end

	assign trial = {rem_q, keysh_q[KW-1]};
	assign diff  = trial - {1'b0, div_q};

	assign hd_valid = head_rd_q[HW-1];
	assign hd_idx   = head_rd_q[NW-1:0];
	assign {nd_key, nd_rec, nd_link_valid, nd_link} = node_rd_q;

	assign node_raddr = ctl.node_rd_link ? nd_link : hd_idx;
	assign hwe        = ctl.sweep_wr | ctl.insert_wr;
	assign haddr      = ctl.sweep_wr ? swcnt_q : rem_q[BW-1:0];
	assign hwdata     = ctl.sweep_wr ? '0 : {1'b1, free_q[NW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q        <= chte_pkg::BC_RESET;
			free_q      <= '0;
			swcnt_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				bc_q <= cfg_wdata;
			end
			if (ctl.sweep_start) begin
				free_q <= '0;
			end else if (ctl.insert_wr) begin
				free_q <= free_q + FW'(1);
			end
			if (ctl.sweep_start) begin
				swcnt_q <= '0;
			end else if (ctl.sweep_wr) begin
				swcnt_q <= swcnt_q + BW'(1);
			end
			if (ctl.load) begin
				cnt_q <= '0;
			end else if (ctl.div_step) begin
				cnt_q <= cnt_q + chte_pkg::BITCNT_W'(1);
			end
			if (ctl.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q   <= key;
			keysh_q <= key;
			rec_q   <= record;
			div_q   <= eff_c[EW-1:0];
			rem_q   <= '0;
			found_q <= '0;
			coll_q  <= '0;
		end else begin
			if (ctl.div_step) begin
				keysh_q <= {keysh_q[KW-2:0], 1'b0};
				if (trial >= {1'b0, div_q}) begin
					rem_q <= diff[EW-1:0];
				end else begin
					rem_q <= trial[EW-1:0];
				end
			end
			if (ctl.found_ld) begin
				found_q <= nd_rec;
			end
			if (ctl.coll_inc && coll_q != chte_pkg::COLL_MAX) begin
				coll_q <= coll_q + chte_pkg::COLL_W'(1);
			end
		end
		if (ctl.res_ld) begin
			status_q    <= ctl.res_status;
			found_out_q <= found_q;
			coll_out_q  <= coll_q;
		end
	end

	always_ff @(posedge clk) begin
		if (hwe) begin
			head_mem[haddr] <= hwdata;
		end
		if (ctl.head_rd) begin
			head_rd_q <= head_mem[rem_q[BW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert_wr) begin
			node_mem[free_q[NW-1:0]] <= {key_q, rec_q, hd_valid, hd_idx};
		end
		if (ctl.node_rd_head || ctl.node_rd_link) begin
			node_rd_q <= node_mem[node_raddr];
		end
	end

	always_comb begin
		stat.div_last   = (cnt_q == chte_pkg::DIV_LAST);
		stat.hd_valid   = hd_valid;
		stat.key_match  = (nd_key == key_q);
		stat.link_valid = nd_link_valid;
		stat.pool_full  = (free_q == FW'(POOL_NODES));
		stat.sweep_last = (swcnt_q == BW'(MAX_BUCKETS - 1));
		stat.out_busy   = out_valid_q & ~out_ready;
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_record = found_out_q;
	assign collisions   = coll_out_q;

endmodule
`default_nettype wire

/* design/chained_hash_table_engine_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit
// Key-to-record hash table with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries cmd, key and record; the output
// channel (out_valid/out_ready) returns status, found_record and collisions,
// one result transaction per input transaction, in order.
// Bucket count is written through cfg_we/cfg_wdata; the user must write it
// only while the unit is idle, as the block does not enforce this. One item
// is worked at a time. The bucket index comes from a bit-serial remainder
// unit, one key bit per cycle; a lookup then reads the chain nodes one at a
// time through the single read port of the node memory. Clear sweeps the
// bucket head memory, one entry per cycle. After reset the same sweep runs
// and in_ready stays low meanwhile; bucket count returns to 256.
// A finished result sits in the output register; the next item is taken
// while it waits, and the unit holds its following result until out_ready.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_unit #(
	parameter int MAX_BUCKETS = chte_pkg::MAX_BUCKETS_DEF,
	parameter int POOL_NODES  = chte_pkg::POOL_NODES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [chte_pkg::BC_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    cmd,
	input  wire logic [chte_pkg::KEY_W-1:0]    key,
	input  wire logic [chte_pkg::REC_W-1:0]    record,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         status,
	output logic [chte_pkg::REC_W-1:0]         found_record,
	output logic [chte_pkg::COLL_W-1:0]        collisions
);

	chte_pkg::ctrl_cmd_t ctl;
	chte_pkg::dp_stat_t  stat;

	chte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat),
		.ctl      (ctl)
	);

	chte_dp #(
		.MAX_BUCKETS (MAX_BUCKETS),
		.POOL_NODES  (POOL_NODES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.key          (key),
		.record       (record),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.found_record (found_record),
		.collisions   (collisions),
		.ctl          (ctl),
		.stat         (stat)
	);

`ifndef NO_ASSERTIONS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken on consecutive cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == chte_pkg::ST_OK || status == chte_pkg::ST_MISS ||
			status == chte_pkg::ST_FULL))
		else $error("unused status code");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != chte_pkg::ST_OK) |-> found_record == '0)
		else $error("record returned without a match");

	a_full_no_coll: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == chte_pkg::ST_FULL) |-> collisions == '0)
		else $error("collisions on a full pool");
`endif

endmodule
`default_nettype wire
